@@ src/assert_macros.svh @@
// Assertion macros shared by the speed meter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WESM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("speed meter assertion failed");

// next-cycle implication
`define WESM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("speed meter assertion failed");

`endif

@@ src/wesm_pkg.sv @@
// Types and constants of the wheel encoder speed meter.
// No dependencies; used by wesm_cfg, wesm_ctrl, wesm_dp, the top level and the testbench.
package wesm_pkg;

	localparam logic [3:0] RegDirection = 4'd0;
	localparam logic [3:0] RegDistance  = 4'd1;
	localparam logic [3:0] RegWeight    = 4'd2;
	localparam logic [3:0] RegTimeout   = 4'd3;

	localparam logic        DirectionReset = 1'b1;
	localparam logic [15:0] DistanceReset  = 16'd1000;
	localparam logic [8:0]  WeightReset    = 9'd64;
	localparam logic [23:0] TimeoutReset   = 24'd600000;

	localparam logic [8:0]         WeightFull = 9'd256;
	localparam logic signed [10:0] UmToMm     = 11'sd1000;
	localparam int                 DivBits    = 36;

	typedef struct packed {
		logic [3:0]  ring_index;
		logic [31:0] edge_time_us;
		logic [31:0] now_us;
	} upd_t;

	typedef struct packed {
		logic signed [31:0] edge_total;
		logic signed [15:0] speed_mm_s;
		logic signed [15:0] speed_avg_mm_s;
	} res_t;

	typedef struct packed {
		logic [3:0]  index;
		logic [23:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic        direction_forward;
		logic [15:0] distance_per_edge_um;
		logic [8:0]  average_weight;
		logic [23:0] stall_timeout_us;
	} cfg_regs_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic mul1;
		logic mul2;
		logic div_init;
		logic div_step;
		logic avg1;
		logic avg2;
		logic commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic go;
	} stat_t;

endpackage

@@ src/wesm_chan_if.sv @@
// Valid/ready channel interface carrying one payload per transfer.
// Payload type given per instance, usually a struct from wesm_pkg.
interface wesm_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ src/wheel_encoder_speed_meter_top.sv @@
// Top level of the wheel encoder speed meter.
// Depends on wesm_pkg, wesm_chan_if, wesm_cfg, wesm_ctrl, wesm_dp, assert_macros.svh.
//
//  channel   role    payload
//  updates   sink    ring_index, edge_time_us, now_us
//  results   source  edge_total, speed_mm_s, speed_avg_mm_s
//  cfg       sink    index, data (register write)
//
// An update without a speed computation goes from evaluation to the result load;
// one with it also runs the multiply, 36-step restoring divide and average steps.
// One update at a time; the result register lets the next update enter
// while the previous result waits. A stalled result blocks only at the end.
// arst_n clears control and running state and loads the register reset values.
`include "assert_macros.svh"

module wheel_encoder_speed_meter_top #(
	parameter int RING_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	wesm_chan_if.sink     updates,
	wesm_chan_if.source   results,
	wesm_chan_if.sink     cfg
);

	wesm_pkg::cfg_regs_t regs;
	wesm_pkg::cmd_t      cmd;
	wesm_pkg::stat_t     stat;
	wesm_pkg::res_t      res;

	wesm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	wesm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (updates.valid),
		.in_ready  (updates.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wesm_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.upd    (updates.payload),
		.regs   (regs),
		.res    (res)
	);

	assign results.payload = res;

	`WESM_ASSERT_NXT(a_busy_after_transfer, clk, arst_n, updates.valid && updates.ready, !updates.ready)
	`WESM_ASSERT_IMP(a_cmd_onehot0, clk, arst_n, 1'b1, $onehot0(cmd))
	`WESM_ASSERT_NXT(a_load_sets_valid, clk, arst_n, cmd.load_out, results.valid)

endmodule

@@ src/wesm_cfg.sv @@
// Configuration register file of the speed meter.
// Depends on wesm_pkg and wesm_chan_if.
module wesm_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	wesm_chan_if.sink              cfg,
	output wesm_pkg::cfg_regs_t    regs
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.direction_forward    <= wesm_pkg::DirectionReset;
			regs.distance_per_edge_um <= wesm_pkg::DistanceReset;
			regs.average_weight       <= wesm_pkg::WeightReset;
			regs.stall_timeout_us     <= wesm_pkg::TimeoutReset;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				wesm_pkg::RegDirection: regs.direction_forward <= cfg.payload.data[0];
				wesm_pkg::RegDistance:  regs.distance_per_edge_um <= cfg.payload.data[15:0];
				wesm_pkg::RegWeight:    regs.average_weight <= cfg.payload.data[8:0];
				wesm_pkg::RegTimeout:   regs.stall_timeout_us <= cfg.payload.data;
				default: begin
				end
			endcase
		end
	end

endmodule

@@ src/wesm_ctrl.sv @@
// Sequencer of the speed meter: steps the datapath through one update.
// Depends on wesm_pkg.
module wesm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  wesm_pkg::stat_t  stat,
	output wesm_pkg::cmd_t   cmd
);

	localparam int CntW = $clog2(wesm_pkg::DivBits);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_EVAL  = 10'b0000000010,
		S_MUL1  = 10'b0000000100,
		S_MUL2  = 10'b0000001000,
		S_DINIT = 10'b0000010000,
		S_DIV   = 10'b0000100000,
		S_AVG1  = 10'b0001000000,
		S_AVG2  = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic            out_valid_q;
	logic            div_last;

	assign div_last  = cnt_q == CntW'(wesm_pkg::DivBits - 1);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.go ? S_MUL1 : S_DONE;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last)
					state_d = S_AVG1;
			end
			S_AVG1: begin
				cmd.avg1 = 1'b1;
				state_d  = S_AVG2;
			end
			S_AVG2: begin
				cmd.avg2 = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/wesm_dp.sv @@
// Datapath of the speed meter: edge counting, speed multiply, serial
// divide, saturation, running average and result register. Depends on wesm_pkg.
module wesm_dp #(
	parameter int RING_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wesm_pkg::cmd_t       cmd,
	output wesm_pkg::stat_t      stat,
	input  wesm_pkg::upd_t       upd,
	input  wesm_pkg::cfg_regs_t  regs,
	output wesm_pkg::res_t       res
);

	localparam int ModW     = $clog2(RING_DEPTH + 16) + 1;
	localparam int ModSteps = (15 + RING_DEPTH - 1) / RING_DEPTH;
	localparam int IdxW     = $clog2(RING_DEPTH);
	localparam int QW       = wesm_pkg::DivBits;
	localparam logic signed [ModW-1:0] Depth = ModW'(RING_DEPTH);

	// captured update
	logic [3:0]  idx_q;
	logic [31:0] edge_time_q;
	logic [31:0] now_q;

	// persistent state
	logic [3:0]         last_idx_q;
	logic [31:0]        edge_sum_q;
	logic signed [10:0] pend_q;
	logic [31:0]        last_upd_q;
	logic signed [15:0] spd_q;
	logic signed [23:0] avg_q;

	// working registers
	logic [31:0]        dt_q;
	logic signed [26:0] prod1_q;
	logic signed [36:0] num_q;
	logic [QW-1:0]      quo_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q;
	logic signed [33:0] prod_a_q;
	logic signed [25:0] prod_b_q;
	wesm_pkg::res_t     res_q;

	logic signed [ModW-1:0] mod_v;
	logic [IdxW-1:0]        d_mag;
	logic signed [IdxW:0]   d_s;
	logic                   d_nz;
	logic [31:0]            dt;
	logic [31:0]            dtn;
	logic                   stall;
	logic [8:0]             w_eff;
	logic [8:0]             w_inv;
	logic signed [36:0]     num_mag;
	logic [32:0]            rem_sh;
	logic                   rem_ge;
	logic signed [15:0]     sat;
	logic signed [34:0]     acc;
	logic signed [34:0]     acc_r;
	logic signed [23:0]     avg_r;

	always_comb begin
		mod_v = ModW'($signed({1'b0, idx_q}) - $signed({1'b0, last_idx_q}));
		for (int i = 0; i < ModSteps; i++) begin
			if (mod_v < 0)
				mod_v = mod_v + Depth;
			else if (mod_v >= Depth)
				mod_v = mod_v - Depth;
		end
	end

	assign d_mag = mod_v[IdxW-1:0];
	assign d_nz  = d_mag != '0;
	assign d_s   = regs.direction_forward ? $signed({1'b0, d_mag}) : -$signed({1'b0, d_mag});
	assign dt    = edge_time_q - last_upd_q;
	assign dtn   = now_q - last_upd_q;
	assign stall = $signed(dtn) > $signed({8'd0, regs.stall_timeout_us});
	assign stat.go = d_nz && (dt != 32'd0);

	assign w_eff = (regs.average_weight > wesm_pkg::WeightFull) ? wesm_pkg::WeightFull
	                                                             : regs.average_weight;
	assign w_inv = wesm_pkg::WeightFull - w_eff;

	assign num_mag = num_q[36] ? -num_q : num_q;
	assign rem_sh  = {rem_q, quo_q[QW-1]};
	assign rem_ge  = rem_sh >= {1'b0, den_q};

	always_comb begin
		if (!neg_q)
			sat = (quo_q > QW'(32767)) ? 16'sh7FFF : $signed(quo_q[15:0]);
		else
			sat = (quo_q > QW'(32768)) ? 16'sh8000 : $signed(16'(17'd0 - quo_q[16:0]));
	end

	// average update, quotient by 256 truncated toward zero
	assign acc   = 35'(prod_a_q) + 35'($signed({prod_b_q, 8'd0}));
	assign acc_r = acc + (acc[34] ? 35'sd255 : 35'sd0);
	assign avg_r = avg_q + (avg_q[23] ? 24'sd255 : 24'sd0);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			idx_q       <= upd.ring_index;
			edge_time_q <= upd.edge_time_us;
			now_q       <= upd.now_us;
		end
		if (cmd.eval)
			dt_q <= dt;
		if (cmd.mul1)
			prod1_q <= pend_q * $signed({1'b0, regs.distance_per_edge_um});
		if (cmd.mul2)
			num_q <= prod1_q * wesm_pkg::UmToMm;
		if (cmd.div_init) begin
			quo_q <= num_mag[QW-1:0];
			rem_q <= '0;
			den_q <= dt_q[31] ? 32'd0 - dt_q : dt_q;
			neg_q <= num_q[36] ^ dt_q[31];
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			quo_q <= {quo_q[QW-2:0], rem_ge};
		end
		if (cmd.avg1)
			prod_a_q <= avg_q * $signed({1'b0, w_inv});
		if (cmd.avg2)
			prod_b_q <= spd_q * $signed({1'b0, w_eff});
		if (cmd.load_out) begin
			res_q.edge_total     <= $signed(edge_sum_q);
			res_q.speed_mm_s     <= spd_q;
			res_q.speed_avg_mm_s <= 16'(avg_r >>> 8);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= '0;
			edge_sum_q <= '0;
			pend_q     <= '0;
			last_upd_q <= '0;
			spd_q      <= '0;
			avg_q      <= '0;
		end else begin
			if (cmd.eval) begin
				if (d_nz) begin
					edge_sum_q <= edge_sum_q + 32'(d_s);
					last_idx_q <= idx_q;
					pend_q     <= pend_q + 11'(d_s);
				end else if (stall) begin
					spd_q      <= '0;
					avg_q      <= '0;
					pend_q     <= '0;
					last_upd_q <= now_q;
				end
			end
			if (cmd.avg1)
				spd_q <= sat;
			if (cmd.commit) begin
				avg_q <= 24'(acc_r >>> 8);
				if (pend_q != 11'sd0)
					last_upd_q <= edge_time_q;
				pend_q <= '0;
			end
		end
	end

	assign res = res_q;

endmodule

@@ tb/wheel_encoder_speed_meter_top_tb.sv @@
// Self-checking testbench for wheel_encoder_speed_meter_top: directed and random encoder
// updates are checked against an in-bench speed/average predictor, over several register settings.
// Depends on wesm_pkg, wesm_chan_if and the RTL of the block.
`timescale 1ns / 1ps

module wheel_encoder_speed_meter_top_tb;

	typedef struct {
		logic               forward;
		logic [15:0]        dist_um;
		logic [8:0]         weight;
		logic [23:0]        timeout;
		logic [3:0]         last_idx;
		logic [31:0]        edge_sum;
		logic signed [10:0] pending;
		logic [31:0]        last_upd;
		logic signed [15:0] speed;
		logic signed [23:0] avg;
	} meter_t;

	typedef struct {
		wesm_pkg::upd_t item;
		bit             hold;
	} queued_upd_t;

	logic clk;
	logic arst_n;

	wesm_chan_if #(.payload_t(wesm_pkg::upd_t))    upd_if ();
	wesm_chan_if #(.payload_t(wesm_pkg::res_t))    res_if ();
	wesm_chan_if #(.payload_t(wesm_pkg::cfg_wr_t)) cfg_if ();

	wheel_encoder_speed_meter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.updates(upd_if),
		.results(res_if),
		.cfg(cfg_if)
	);

	meter_t         meter;
	meter_t         plan_meter;
	queued_upd_t    update_q[$];
	wesm_pkg::res_t due_reports[$];
	bit             upd_live;
	int             send_idle_pct;
	int             recv_idle_pct;
	logic [31:0]    gen_now;
	int             mismatches;
	int             updates_done;
	int             reports_checked;
	int             settings_used;

	function automatic void advance_meter(inout meter_t m, input wesm_pkg::upd_t u,
	                                      output wesm_pkg::res_t r);
		logic [3:0] adv;
		int         steps;
		int         dt_edge;
		int         dt_now;
		longint     quo;
		longint     w;
		longint     acc;
		adv = u.ring_index - m.last_idx;
		dt_now = $signed(u.now_us - m.last_upd);
		if (adv != 0) begin
			steps = m.forward ? int'(adv) : -int'(adv);
			m.edge_sum = m.edge_sum + steps;
			m.last_idx = u.ring_index;
			m.pending = m.pending + 11'(steps);
			dt_edge = $signed(u.edge_time_us - m.last_upd);
			if (dt_edge != 0) begin
				quo = longint'(m.pending) * longint'(m.dist_um) * 1000 / dt_edge;
				if (quo > 32767)
					quo = 32767;
				else if (quo < -32768)
					quo = -32768;
				m.speed = 16'(quo);
				w = (m.weight > wesm_pkg::WeightFull) ? 256 : longint'(m.weight);
				acc = longint'(m.avg) * (256 - w) + longint'(m.speed) * 256 * w;
				m.avg = 24'(acc / 256);
				if (m.pending != 0)
					m.last_upd = u.edge_time_us;
				m.pending = '0;
			end
		end else if (dt_now > int'(m.timeout)) begin
			m.speed = '0;
			m.avg = '0;
			m.pending = '0;
			m.last_upd = u.now_us;
		end
		r.edge_total = m.edge_sum;
		r.speed_mm_s = m.speed;
		r.speed_avg_mm_s = 16'(int'(m.avg) / 256);
	endfunction

	task automatic push_upd(input logic [3:0] idx, input logic [31:0] stamp,
	                        input logic [31:0] now_t, input bit hold = 1'b0);
		queued_upd_t    q;
		wesm_pkg::res_t unused;
		q.item = '{ring_index: idx, edge_time_us: stamp, now_us: now_t};
		q.hold = hold;
		advance_meter(plan_meter, q.item, unused);
		update_q.push_back(q);
	endtask

	task automatic push_motion();
		int adv;
		adv = ($urandom_range(9) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
		gen_now += $urandom_range(100, 4000);
		push_upd(4'(plan_meter.last_idx + adv), gen_now - $urandom_range(0, 80), gen_now,
		         $urandom_range(29) == 0);
	endtask

	task automatic wait_idle();
		while (update_q.size() != 0 || upd_live || due_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [23:0] data);
		@(negedge clk);
		cfg_if.payload <= '{index: idx, data: data};
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			wesm_pkg::RegDirection: meter.forward = data[0];
			wesm_pkg::RegDistance:  meter.dist_um = data[15:0];
			wesm_pkg::RegWeight:    meter.weight = data[8:0];
			wesm_pkg::RegTimeout:   meter.timeout = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_config(input bit fwd, input logic [15:0] dist_um,
	                          input logic [8:0] weight, input logic [23:0] tmo);
		wait_idle();
		write_reg(wesm_pkg::RegDirection, {23'd0, fwd});
		write_reg(wesm_pkg::RegDistance, {8'd0, dist_um});
		write_reg(wesm_pkg::RegWeight, {15'd0, weight});
		write_reg(wesm_pkg::RegTimeout, tmo);
		plan_meter = meter;
		settings_used++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// update channel driver; results receiver
	always @(negedge clk) begin : drive_updates
		queued_upd_t q;
		if (arst_n && !upd_live) begin
			if (update_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
			    !(update_q[0].hold && due_reports.size() != 0)) begin
				q = update_q.pop_front();
				upd_if.payload <= q.item;
				upd_if.valid <= 1'b1;
				upd_live = 1'b1;
			end else begin
				upd_if.valid <= 1'b0;
			end
		end
		if (arst_n)
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : watch_transfers
		wesm_pkg::res_t want;
		wesm_pkg::res_t got;
		wesm_pkg::res_t next;
		if (arst_n) begin
			if (upd_if.valid && upd_if.ready) begin
				advance_meter(meter, upd_if.payload, next);
				due_reports.push_back(next);
				upd_live = 1'b0;
				updates_done++;
			end
			if (res_if.valid && res_if.ready) begin
				got = res_if.payload;
				if (due_reports.size() == 0) begin
					$error("result transfer with nothing expected");
					mismatches++;
				end else begin
					want = due_reports.pop_front();
					reports_checked++;
					if (got.edge_total !== want.edge_total) begin
						$error("edge_total: expected %0d, got %0d",
						       want.edge_total, got.edge_total);
						mismatches++;
					end
					if (got.speed_mm_s !== want.speed_mm_s) begin
						$error("speed_mm_s: expected %0d, got %0d",
						       want.speed_mm_s, got.speed_mm_s);
						mismatches++;
					end
					if (got.speed_avg_mm_s !== want.speed_avg_mm_s) begin
						$error("speed_avg_mm_s: expected %0d, got %0d",
						       want.speed_avg_mm_s, got.speed_avg_mm_s);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int          p;
		int          n;
		int          k;
		int          r;
		logic [15:0] dist_um;
		logic [8:0]  weight;
		logic [23:0] tmo;
		arst_n = 1'b0;
		upd_if.valid = 1'b0;
		upd_if.payload = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		upd_live = 1'b0;
		mismatches = 0;
		updates_done = 0;
		reports_checked = 0;
		settings_used = 0;
		send_idle_pct = 7;
		recv_idle_pct = 77;
		meter = '{forward: wesm_pkg::DirectionReset, dist_um: wesm_pkg::DistanceReset,
		          weight: wesm_pkg::WeightReset, timeout: wesm_pkg::TimeoutReset,
		          last_idx: '0, edge_sum: '0, pending: '0,
		          last_upd: '0, speed: '0, avg: '0};
		plan_meter = meter;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: saturation, zero and negative elapsed time, stalls, wraps
		set_config(1'b1, 16'd1000, 9'd64, 24'd600000);
		push_upd(4'd0, 32'd0, 32'd0);
		push_upd(4'd3, 32'd1000, 32'd1000);
		push_upd(4'd15, 32'd1000, 32'd1500);
		push_upd(4'd0, 32'd2000, 32'd2100, 1'b1);
		push_upd(4'd1, 32'd2001, 32'd2101);
		push_upd(4'd2, 32'd2000, 32'd2102);
		push_upd(4'd2, 32'hFFFF_FFFF, 32'd602001);
		push_upd(4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_upd(4'd7, 32'd0, 32'd0);
		push_upd(4'd12, 32'hFFFF_FFFF, 32'd5);
		// reverse direction cancels the edges left pending
		set_config(1'b0, 16'd1000, 9'd64, 24'd0);
		push_upd(4'd1, 32'h10, 32'h10);
		push_upd(4'd1, 32'd0, 32'h11);
		push_upd(4'd1, 32'd0, 32'h11);
		push_upd(4'd5, 32'h205, 32'h210);
		set_config(1'b1, 16'hFFFF, wesm_pkg::WeightFull, 24'hFFFFFF);
		push_upd(4'd6, 32'h5ED, 32'h5ED);
		push_upd(4'd15, 32'h8000_0000, 32'h8000_0000);
		push_upd(4'd15, 32'd0, 32'h8000_0000 + 32'h0100_0000);
		set_config(1'b1, 16'd0, 9'd0, 24'd600000);
		push_upd(4'd0, plan_meter.last_upd + 100, plan_meter.last_upd + 100);
		push_upd(4'd8, plan_meter.last_upd + 7, plan_meter.last_upd + 9);
		set_config(1'b1, 16'd1000, 9'd300, 24'd600000);
		push_upd(4'd10, plan_meter.last_upd + 1000, plan_meter.last_upd + 1000);
		push_upd(4'd10, $urandom, plan_meter.last_upd + 600000);
		push_upd(4'd10, 32'd0, plan_meter.last_upd + 600001);

		for (p = 0; p < 9; p++) begin
			send_idle_pct = (p < 3) ? 7 : (p < 6) ? 77 : 0;
			recv_idle_pct = (p < 3) ? 77 : (p < 6) ? 7 : 0;
			case (p)
				2:       dist_um = 16'hFFFF;
				6:       dist_um = 16'd0;
				default: dist_um = 16'($urandom_range(100, 3000));
			endcase
			case (p)
				1:       weight = wesm_pkg::WeightFull;
				4:       weight = 9'd0;
				7:       weight = 9'($urandom_range(257, 511));
				default: weight = 9'($urandom_range(1, 255));
			endcase
			case (p)
				0, 6:    tmo = 24'd600000;
				3:       tmo = 24'd0;
				5:       tmo = 24'hFFFFFF;
				default: tmo = 24'($urandom_range(300, 20000));
			endcase
			set_config(p % 2 == 0, dist_um, weight, tmo);
			gen_now = plan_meter.last_upd;
			n = 0;
			if (p == 1 || p == 6) begin
				// long run at one timestamp so the pending count can wrap
				repeat (76) begin
					gen_now += 40;
					push_upd(4'(plan_meter.last_idx + $urandom_range(12, 15)),
					         plan_meter.last_upd, gen_now);
				end
				gen_now += 500;
				push_upd(4'(plan_meter.last_idx + 1), gen_now, gen_now, 1'b1);
				n += 77;
			end
			while (n < 52) begin
				r = $urandom_range(99);
				if (r < 55) begin
					k = $urandom_range(1, 6);
					repeat (k) push_motion();
					n += k;
				end else if (r < 70) begin
					k = $urandom_range(1, 4);
					repeat (k) begin
						gen_now += $urandom_range(10, 500);
						push_upd(4'(plan_meter.last_idx + $urandom_range(1, 15)),
						         plan_meter.last_upd, gen_now);
					end
					push_motion();
					n += k + 1;
				end else if (r < 78) begin
					gen_now = plan_meter.last_upd + plan_meter.timeout + $urandom_range(0, 40);
					push_upd(plan_meter.last_idx, $urandom, gen_now);
					n++;
				end else if (r < 85) begin
					gen_now += $urandom_range(10, 300);
					push_upd(4'(plan_meter.last_idx + $urandom_range(1, 15)),
					         plan_meter.last_upd - $urandom_range(1, 3000), gen_now);
					n++;
				end else if (r < 93) begin
					push_upd(4'($urandom), $urandom, $urandom);
					n++;
				end else begin
					gen_now += $urandom_range(1, 200);
					push_upd(plan_meter.last_idx, $urandom, gen_now);
					n++;
				end
			end
		end

		wait_idle();
		repeat (60) @(posedge clk);
		if (due_reports.size() != 0) begin
			$error("%0d expected results never arrived", due_reports.size());
			mismatches++;
		end
		$display("Ran %0d encoder updates under %0d register settings; %0d results compared.",
		         updates_done, settings_used, reports_checked);
		$display("Covered stalls, pending wrap, saturation and three handshake idle patterns.");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/wesm_pkg.sv
src/wesm_chan_if.sv
src/wesm_cfg.sv
src/wesm_ctrl.sv
src/wesm_dp.sv
src/wheel_encoder_speed_meter_top.sv
tb/wheel_encoder_speed_meter_top_tb.sv
